// ===== src/wpd_pkg.sv =====
// package for the wav pcm stream decoder: types, codes, header constants and tag table
`default_nettype none

package wpd_pkg;

  // fixed header length and the position of its last byte
  localparam int unsigned HEADER_BYTES = 44;
  localparam logic [5:0] LAST_HDR_POS = 6'(HEADER_BYTES - 1);

  // iterations of the shift-add multiplier (one per bit of bits_per_sample)
  localparam int unsigned MUL_STEPS = 16;
  localparam logic [3:0] MUL_LAST = 4'(MUL_STEPS - 1);

  // result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // reject reasons
  localparam logic [2:0] REASON_NONE  = 3'd0;
  localparam logic [2:0] REASON_TAGS  = 3'd1;
  localparam logic [2:0] REASON_FMT   = 3'd2;
  localparam logic [2:0] REASON_CHAN  = 3'd3;
  localparam logic [2:0] REASON_RATE  = 3'd4;
  localparam logic [2:0] REASON_WIDTH = 3'd5;

  // header field values that pass
  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] CHAN_MONO = 16'd1;
  localparam logic [15:0] CHAN_STEREO = 16'd2;
  localparam logic [15:0] WIDTH_8 = 16'd8;
  localparam logic [15:0] WIDTH_16 = 16'd16;
  localparam logic [15:0] WIDTH_24 = 16'd24;

  // sequencer states
  typedef enum logic [2:0] {
    ST_HEADER,
    ST_CHECK,
    ST_VERDICT,
    ST_DATA,
    ST_DONE
  } state_t;

  // positions below 16 that carry tag characters (the riff size is skipped)
  function automatic logic is_tag_pos(input logic [5:0] pos);
    logic result;
    result = (pos < 6'd16) && !((pos >= 6'd4) && (pos < 6'd8));
    return result;
  endfunction

  // expected tag character: "RIFF" ... "WAVE" "fmt "
  function automatic logic [7:0] tag_byte(input logic [3:0] pos);
    logic [7:0] result;
    case (pos)
      4'd0:    result = 8'h52;
      4'd1:    result = 8'h49;
      4'd2:    result = 8'h46;
      4'd3:    result = 8'h46;
      4'd8:    result = 8'h57;
      4'd9:    result = 8'h41;
      4'd10:   result = 8'h56;
      4'd11:   result = 8'h45;
      4'd12:   result = 8'h66;
      4'd13:   result = 8'h6d;
      4'd14:   result = 8'h74;
      4'd15:   result = 8'h20;
      default: result = 8'h00;
    endcase
    return result;
  endfunction

endpackage

`default_nettype wire

// ===== src/wav_pcm_stream_decoder.sv =====
// wav pcm stream decoder: header parse and check, shift-add rate check, sample assembly
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  in      | in_valid  | in_stall  | byte_value, start_of_file
//  out     | out_valid | out_stall | result_kind, reject_reason, sample_value,
//          |           |           | channel_index, last_sample
//
// header and data bytes are taken one per cycle while the input is not stalled.
// after the 44th header byte the input stalls while the shift-add multiplier forms
// rate * bits (doubled for stereo) and until the verdict is loaded into the output.
// one output register holds each result; a new item is taken while it drains.
// rst is synchronous and clears the sequencer, header fields and output valid.
`default_nettype none

module wav_pcm_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        start_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [2:0]       reject_reason,
  output logic signed [23:0] sample_value,
  output logic             channel_index,
  output logic             last_sample
);

  wpd_pkg::state_t state, state_next;

  // header fields and data walk state
  logic [5:0]  header_byte_count, header_byte_count_next;
  logic        tags_ok, tags_ok_next;
  logic [15:0] audio_format, audio_format_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] sample_rate, sample_rate_next;
  logic [31:0] byte_rate, byte_rate_next;
  logic [15:0] bits_per_sample, bits_per_sample_next;
  logic [31:0] data_bytes_left, data_bytes_left_next;
  logic [23:0] sample_assembly, sample_assembly_next;
  logic [1:0]  byte_in_sample, byte_in_sample_next;
  logic        current_channel, current_channel_next;

  // rate-check multiplier
  logic [47:0] prod;
  logic [47:0] mcand;
  logic [15:0] mplier;
  logic [3:0]  mul_count;

  // handshake
  logic in_acc;
  logic out_free;
  logic hdr_take;
  logic data_take;
  logic [5:0] hdr_pos;
  logic hdr_last;

  // data path signals
  logic [1:0]  bps;
  logic [23:0] asm_new;
  logic [1:0]  bis_inc;
  logic [31:0] dbl_dec;
  logic        emit;
  logic        last;
  logic [23:0] sample_new;

  // verdict signals
  logic [48:0] full_prod;
  logic [45:0] rate_expect;
  logic        rate_ok;
  logic [2:0]  reason;
  logic        verdict_load;
  logic        sample_load;

  // handshake and take decisions
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state == wpd_pkg::ST_CHECK) || (state == wpd_pkg::ST_VERDICT) ||
                     !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign hdr_take  = in_acc && (start_of_file || (state == wpd_pkg::ST_HEADER));
  assign data_take = in_acc && !start_of_file && (state == wpd_pkg::ST_DATA);
  assign hdr_pos   = start_of_file ? 6'd0 : header_byte_count;
  assign hdr_last  = hdr_pos >= wpd_pkg::LAST_HDR_POS;

  // sample assembly for the current data byte
  assign bps      = bits_per_sample[4:3];
  assign asm_new  = sample_assembly | ({16'h0000, byte_value} << {byte_in_sample, 3'b000});
  assign bis_inc  = byte_in_sample + 2'd1;
  assign dbl_dec  = data_bytes_left - 32'd1;
  assign emit     = bis_inc >= bps;
  assign last     = dbl_dec < {30'd0, bps};

  always_comb begin
    case (bps)
      2'd1:    sample_new = {~asm_new[7], asm_new[6:0], 16'h0000};
      2'd2:    sample_new = {asm_new[15:0], 8'h00};
      default: sample_new = asm_new;
    endcase
  end

  // header verdict, first failing check wins
  assign full_prod   = (channel_count == wpd_pkg::CHAN_STEREO) ? {prod, 1'b0} : {1'b0, prod};
  assign rate_expect = full_prod[48:3];
  assign rate_ok     = {14'd0, byte_rate} == rate_expect;

  always_comb begin
    if (!tags_ok) begin
      reason = wpd_pkg::REASON_TAGS;
    end else if (audio_format != wpd_pkg::FMT_PCM) begin
      reason = wpd_pkg::REASON_FMT;
    end else if (channel_count != wpd_pkg::CHAN_MONO &&
                 channel_count != wpd_pkg::CHAN_STEREO) begin
      reason = wpd_pkg::REASON_CHAN;
    end else if (!rate_ok) begin
      reason = wpd_pkg::REASON_RATE;
    end else if (bits_per_sample != wpd_pkg::WIDTH_8 &&
                 bits_per_sample != wpd_pkg::WIDTH_16 &&
                 bits_per_sample != wpd_pkg::WIDTH_24) begin
      reason = wpd_pkg::REASON_WIDTH;
    end else begin
      reason = wpd_pkg::REASON_NONE;
    end
  end

  assign verdict_load = (state == wpd_pkg::ST_VERDICT) && out_free;
  assign sample_load  = data_take && emit;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wpd_pkg::ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wpd_pkg::ST_CHECK: begin
        if (mul_count == wpd_pkg::MUL_LAST) begin
          state_next = wpd_pkg::ST_VERDICT;
        end
      end
      wpd_pkg::ST_VERDICT: begin
        if (out_free) begin
          if (reason != wpd_pkg::REASON_NONE || data_bytes_left < {30'd0, bps}) begin
            state_next = wpd_pkg::ST_DONE;
          end else begin
            state_next = wpd_pkg::ST_DATA;
          end
        end
      end
      wpd_pkg::ST_HEADER, wpd_pkg::ST_DATA, wpd_pkg::ST_DONE: begin
        if (hdr_take) begin
          state_next = hdr_last ? wpd_pkg::ST_CHECK : wpd_pkg::ST_HEADER;
        end else if (sample_load && last) begin
          state_next = wpd_pkg::ST_DONE;
        end
      end
      default: state_next = wpd_pkg::ST_HEADER;
    endcase
  end

  // header field capture and data walk
  always_comb begin
    header_byte_count_next = start_of_file ? 6'd0 : header_byte_count;
    tags_ok_next           = start_of_file ? 1'b1 : tags_ok;
    audio_format_next      = start_of_file ? 16'd0 : audio_format;
    channel_count_next     = start_of_file ? 16'd0 : channel_count;
    sample_rate_next       = start_of_file ? 32'd0 : sample_rate;
    byte_rate_next         = start_of_file ? 32'd0 : byte_rate;
    bits_per_sample_next   = start_of_file ? 16'd0 : bits_per_sample;
    data_bytes_left_next   = start_of_file ? 32'd0 : data_bytes_left;
    sample_assembly_next   = start_of_file ? 24'd0 : sample_assembly;
    byte_in_sample_next    = start_of_file ? 2'd0 : byte_in_sample;
    current_channel_next   = start_of_file ? 1'b0 : current_channel;
    if (hdr_take) begin
      header_byte_count_next = hdr_pos + 6'd1;
      if (wpd_pkg::is_tag_pos(hdr_pos) && byte_value != wpd_pkg::tag_byte(hdr_pos[3:0])) begin
        tags_ok_next = 1'b0;
      end
      if (hdr_pos inside {[6'd20:6'd21]}) begin
        audio_format_next[{hdr_pos[0], 3'b000} +: 8] = byte_value;
      end else if (hdr_pos inside {[6'd22:6'd23]}) begin
        channel_count_next[{hdr_pos[0], 3'b000} +: 8] = byte_value;
      end else if (hdr_pos inside {[6'd24:6'd27]}) begin
        sample_rate_next[{hdr_pos[1:0], 3'b000} +: 8] = byte_value;
      end else if (hdr_pos inside {[6'd28:6'd31]}) begin
        byte_rate_next[{hdr_pos[1:0], 3'b000} +: 8] = byte_value;
      end else if (hdr_pos inside {[6'd34:6'd35]}) begin
        bits_per_sample_next[{hdr_pos[0], 3'b000} +: 8] = byte_value;
      end else if (hdr_pos inside {[6'd40:6'd43]}) begin
        data_bytes_left_next[{hdr_pos[1:0], 3'b000} +: 8] = byte_value;
      end
    end else if (data_take) begin
      data_bytes_left_next = dbl_dec;
      if (emit) begin
        sample_assembly_next = 24'd0;
        byte_in_sample_next  = 2'd0;
        current_channel_next = (channel_count == wpd_pkg::CHAN_STEREO) ? ~current_channel : 1'b0;
      end else begin
        sample_assembly_next = asm_new;
        byte_in_sample_next  = bis_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte_count <= 6'd0;
      tags_ok           <= 1'b1;
      audio_format      <= 16'd0;
      channel_count     <= 16'd0;
      sample_rate       <= 32'd0;
      byte_rate         <= 32'd0;
      bits_per_sample   <= 16'd0;
      data_bytes_left   <= 32'd0;
      sample_assembly   <= 24'd0;
      byte_in_sample    <= 2'd0;
      current_channel   <= 1'b0;
    end else if (in_acc) begin
      header_byte_count <= header_byte_count_next;
      tags_ok           <= tags_ok_next;
      audio_format      <= audio_format_next;
      channel_count     <= channel_count_next;
      sample_rate       <= sample_rate_next;
      byte_rate         <= byte_rate_next;
      bits_per_sample   <= bits_per_sample_next;
      data_bytes_left   <= data_bytes_left_next;
      sample_assembly   <= sample_assembly_next;
      byte_in_sample    <= byte_in_sample_next;
      current_channel   <= current_channel_next;
    end
  end

  // shift-add multiplier: sample_rate * bits_per_sample, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_count <= 4'd0;
    end else if (hdr_take && hdr_last) begin
      mul_count <= 4'd0;
    end else if (state == wpd_pkg::ST_CHECK) begin
      mul_count <= mul_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_take && hdr_last) begin
      prod   <= 48'd0;
      mcand  <= {16'd0, sample_rate_next};
      mplier <= bits_per_sample_next;
    end else if (state == wpd_pkg::ST_CHECK) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= {mcand[46:0], 1'b0};
      mplier <= {1'b0, mplier[15:1]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (verdict_load || sample_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict_load) begin
      result_kind   <= (reason == wpd_pkg::REASON_NONE) ? wpd_pkg::KIND_ACCEPT :
                                                          wpd_pkg::KIND_REJECT;
      reject_reason <= reason;
      sample_value  <= 24'sd0;
      channel_index <= 1'b0;
      last_sample   <= 1'b0;
    end else if (sample_load) begin
      result_kind   <= wpd_pkg::KIND_SAMPLE;
      reject_reason <= wpd_pkg::REASON_NONE;
      sample_value  <= sample_new;
      channel_index <= current_channel;
      last_sample   <= last;
    end
  end

`ifndef SYNTH
  // input is held off while the rate check runs
  assert property (@(posedge clk) disable iff (rst)
    (state == wpd_pkg::ST_CHECK || state == wpd_pkg::ST_VERDICT) |-> in_stall)
    else $error("item taken during header check");

  // multiplier ends after its last step
  assert property (@(posedge clk) disable iff (rst)
    (state == wpd_pkg::ST_CHECK && mul_count == wpd_pkg::MUL_LAST) |=>
    (state == wpd_pkg::ST_VERDICT))
    else $error("multiplier did not finish on time");

  // a verdict moves on to the data walk or to done with a result shown
  assert property (@(posedge clk) disable iff (rst)
    verdict_load |=> (out_valid && (state == wpd_pkg::ST_DATA || state == wpd_pkg::ST_DONE)))
    else $error("verdict not delivered");

  // a sample only follows an accepted header of a supported width
  assert property (@(posedge clk) disable iff (rst)
    sample_load |-> (bps != 2'd0 && reason == wpd_pkg::REASON_NONE))
    else $error("sample emitted without an accepted header");

  // the data walk never runs past the end of the chunk
  assert property (@(posedge clk) disable iff (rst)
    (state == wpd_pkg::ST_DATA) |-> (data_bytes_left != 32'd0))
    else $error("data walk past the chunk end");
`endif

endmodule

`default_nettype wire

// ===== tb/wav_decode_checker.sv =====
// checker for the wav pcm stream decoder: predicts each result from the accepted bytes and compares
`default_nettype none

module wav_decode_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [7:0]         byte_value,
  input  wire logic               start_of_file,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         result_kind,
  input  wire logic [2:0]         reject_reason,
  input  wire logic signed [23:0] sample_value,
  input  wire logic               channel_index,
  input  wire logic               last_sample,
  output int                      fail_count,
  output int                      pending,
  output int                      n_samples,
  output int                      n_accepts,
  output int                      n_rejects
);

  localparam int MAX_REPORTS = 10;
  // tag characters by header position, "RIFF" size "WAVE" "fmt "
  localparam logic [127:0] TAG_TEXT = {"RIFF", 32'h0, "WAVE", "fmt "};

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  reason;
    logic [23:0] value;
    logic        chan;
    logic        is_last;
  } wav_result_t;

  typedef enum logic [1:0] {
    WALK_HEADER,
    WALK_DATA,
    WALK_DONE
  } walk_t;

  // decoder state as predicted
  walk_t       walk;
  logic [5:0]  hdr_pos;
  logic        tags_ok;
  logic [15:0] audio_fmt;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [31:0] brate;
  logic [15:0] bits;
  logic [31:0] data_left;
  logic [23:0] sample_acc;
  logic [1:0]  lane;
  logic        cur_chan;

  wav_result_t decoded_due[$];
  wav_result_t got;
  wav_result_t want;
  wav_result_t made;
  logic        made_valid;

  // back to the start of a header
  task automatic clear_walk();
    walk       = WALK_HEADER;
    hdr_pos    = '0;
    tags_ok    = 1'b1;
    audio_fmt  = '0;
    chans      = '0;
    rate       = '0;
    brate      = '0;
    bits       = '0;
    data_left  = '0;
    sample_acc = '0;
    lane       = '0;
    cur_chan   = 1'b0;
  endtask

  // first failing header check, in priority order
  function automatic logic [2:0] header_reason();
    logic [63:0] prod;
    prod = {48'h0, chans} * {32'h0, rate} * {48'h0, bits};
    if (!tags_ok) return wpd_pkg::REASON_TAGS;
    if (audio_fmt != wpd_pkg::FMT_PCM) return wpd_pkg::REASON_FMT;
    if (chans != wpd_pkg::CHAN_MONO && chans != wpd_pkg::CHAN_STEREO)
      return wpd_pkg::REASON_CHAN;
    if ({32'h0, brate} != (prod >> 3)) return wpd_pkg::REASON_RATE;
    if (bits != wpd_pkg::WIDTH_8 && bits != wpd_pkg::WIDTH_16 && bits != wpd_pkg::WIDTH_24)
      return wpd_pkg::REASON_WIDTH;
    return wpd_pkg::REASON_NONE;
  endfunction

  // one byte of the file: header parse, verdict, or sample assembly
  task automatic decode_wav_byte(input logic [7:0] b, input logic sof,
                                 output logic emit, output wav_result_t res);
    int pos;
    int bps;
    logic [2:0] reason;
    emit = 1'b0;
    res = '0;
    if (sof) clear_walk();
    bps = bits / 16'd8;
    case (walk)
      WALK_HEADER: begin
        pos = hdr_pos;
        if (pos < 16 && !(pos >= 4 && pos < 8) && b != TAG_TEXT[8*(15-pos) +: 8])
          tags_ok = 1'b0;
        if (pos >= 20 && pos < 22) audio_fmt[8*(pos-20) +: 8] = b;
        else if (pos >= 22 && pos < 24) chans[8*(pos-22) +: 8] = b;
        else if (pos >= 24 && pos < 28) rate[8*(pos-24) +: 8] = b;
        else if (pos >= 28 && pos < 32) brate[8*(pos-28) +: 8] = b;
        else if (pos >= 34 && pos < 36) bits[8*(pos-34) +: 8] = b;
        else if (pos >= 40 && pos < 44) data_left[8*(pos-40) +: 8] = b;
        hdr_pos = hdr_pos + 6'd1;
        if (pos >= wpd_pkg::HEADER_BYTES - 1) begin
          reason = header_reason();
          emit = 1'b1;
          res.kind = (reason == wpd_pkg::REASON_NONE) ? wpd_pkg::KIND_ACCEPT :
                                                        wpd_pkg::KIND_REJECT;
          res.reason = reason;
          bps = bits / 16'd8;
          if (reason != wpd_pkg::REASON_NONE || data_left < bps) walk = WALK_DONE;
          else walk = WALK_DATA;
        end
      end
      WALK_DATA: begin
        sample_acc[8*lane +: 8] = b;
        lane = lane + 2'd1;
        data_left = data_left - 32'd1;
        if (lane >= bps) begin
          emit = 1'b1;
          res.kind = wpd_pkg::KIND_SAMPLE;
          res.reason = wpd_pkg::REASON_NONE;
          // scale every width to q1.23
          case (bps)
            1: res.value = {sample_acc[7:0] ^ 8'h80, 16'h0000};
            2: res.value = {sample_acc[15:0], 8'h00};
            default: res.value = sample_acc;
          endcase
          res.chan = cur_chan;
          res.is_last = (data_left < bps);
          sample_acc = '0;
          lane = '0;
          cur_chan = (chans == wpd_pkg::CHAN_STEREO) ? ~cur_chan : 1'b0;
          if (res.is_last) walk = WALK_DONE;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_walk();
      decoded_due.delete();
      fail_count = 0;
      n_samples = 0;
      n_accepts = 0;
      n_rejects = 0;
    end else begin
      // results leaving the block
      if (out_valid && !out_stall) begin
        got = {result_kind, reject_reason, sample_value, channel_index, last_sample};
        if (decoded_due.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("unexpected result: kind %0d reason %0d value %06h ch %0d last %0d",
                     got.kind, got.reason, got.value, got.chan, got.is_last);
          fail_count++;
        end else begin
          want = decoded_due.pop_front();
          if (got.kind !== want.kind || got.reason !== want.reason ||
              got.value !== want.value || got.chan !== want.chan ||
              got.is_last !== want.is_last) begin
            if (fail_count < MAX_REPORTS)
              $display("result mismatch: want kind %0d reason %0d value %06h ch %0d last %0d, %s",
                       want.kind, want.reason, want.value, want.chan, want.is_last,
                       $sformatf("got kind %0d reason %0d value %06h ch %0d last %0d",
                                 got.kind, got.reason, got.value, got.chan, got.is_last));
            fail_count++;
          end
          case (want.kind)
            wpd_pkg::KIND_SAMPLE: n_samples++;
            wpd_pkg::KIND_ACCEPT: n_accepts++;
            default:              n_rejects++;
          endcase
        end
      end
      // bytes entering the block
      if (in_valid && !in_stall) begin
        decode_wav_byte(byte_value, start_of_file, made_valid, made);
        if (made_valid) decoded_due.insert(decoded_due.size(), made);
      end
    end
    pending = decoded_due.size();
  end

endmodule

`default_nettype wire

// ===== tb/wav_pcm_stream_decoder_tb.sv =====
// testbench top for the wav pcm stream decoder: byte files, random idling, watchdog and verdict
`default_nettype none

module wav_pcm_stream_decoder_tb;

  localparam int RANDOM_BYTES = 300;
  localparam int CALM_AFTER   = 200;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  byte_value = 8'h00;
  logic        start_of_file = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  result_kind;
  logic [2:0]  reject_reason;
  logic signed [23:0] sample_value;
  logic        channel_index;
  logic        last_sample;

  int fail_count;
  int pending;
  int n_samples;
  int n_accepts;
  int n_rejects;

  logic       idle_on = 1'b1;
  int         stall_burst = 0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  int         idle_run;
  logic [7:0] file_bytes[$];

  wav_pcm_stream_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_value    (byte_value),
    .start_of_file (start_of_file),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .reject_reason (reject_reason),
    .sample_value  (sample_value),
    .channel_index (channel_index),
    .last_sample   (last_sample)
  );

  wav_decode_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_value    (byte_value),
    .start_of_file (start_of_file),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .reject_reason (reject_reason),
    .sample_value  (sample_value),
    .channel_index (channel_index),
    .last_sample   (last_sample),
    .fail_count    (fail_count),
    .pending       (pending),
    .n_samples     (n_samples),
    .n_accepts     (n_accepts),
    .n_rejects     (n_rejects)
  );

  always #1 clk = ~clk;

  // receiver stalls in short random bursts
  always @(negedge clk) begin
    if (stall_burst > 0) begin
      out_stall = 1'b1;
      stall_burst--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_burst = $urandom_range(1, 3) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // byte rate that matches the other header fields, cut to 32 bits
  function automatic logic [31:0] byte_rate_of(input logic [15:0] ch, input logic [15:0] bw,
                                               input logic [31:0] sr);
    logic [63:0] prod;
    prod = {48'h0, ch} * {32'h0, sr} * {48'h0, bw};
    return prod[34:3];
  endfunction

  // append a little-endian value
  task automatic put_le(input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) file_bytes = {file_bytes, v[8*i +: 8]};
  endtask

  task automatic put_random(input int n);
    int i;
    for (i = 0; i < n; i++) file_bytes = {file_bytes, 8'($urandom_range(0, 255))};
  endtask

  task automatic trim_to(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endtask

  // fresh 44-byte header; unchecked fields are random
  task automatic build_header(input logic [15:0] fmt, input logic [15:0] ch,
                              input logic [31:0] sr, input logic [31:0] br,
                              input logic [15:0] bw, input logic [31:0] len);
    file_bytes.delete();
    put_le(32'h46464952, 4);   // "RIFF"
    put_le($urandom, 4);
    put_le(32'h45564157, 4);   // "WAVE"
    put_le(32'h20746d66, 4);   // "fmt "
    put_le(($urandom_range(0, 3) == 0) ? $urandom : 32'd16, 4);
    put_le({16'h0000, fmt}, 2);
    put_le({16'h0000, ch}, 2);
    put_le(sr, 4);
    put_le(br, 4);
    put_le($urandom, 2);
    put_le({16'h0000, bw}, 2);
    put_le(($urandom_range(0, 3) == 0) ? $urandom : 32'h61746164, 4);   // "data"
    put_le(len, 4);
  endtask

  // one item, with an optional gap in front
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    byte_value = b;
    start_of_file = sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file(input logic sof);
    int i;
    for (i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], (i == 0) ? sof : 1'b0);
    files_sent++;
  endtask

  // input held idle until every expected result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  // watchdog on cycles with no handshake on either channel
  initial begin : watchdog
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("wav_pcm_stream_decoder_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int flaw;
    int directed_bytes;
    int file_no;
    int cut;
    logic        sof;
    logic [15:0] fmt;
    logic [15:0] ch;
    logic [15:0] bw;
    logic [31:0] sr;
    logic [31:0] br;
    logic [31:0] len;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // mono 8-bit with no start flag after reset, extreme bytes, then ignored junk
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8,
                 32'd4);
    put_le(32'h7F80FF00, 4);
    put_random(2);
    send_file(1'b0);

    // stereo 16-bit with a trailing partial sample
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_STEREO, 32'd44100,
                 byte_rate_of(wpd_pkg::CHAN_STEREO, wpd_pkg::WIDTH_16, 32'd44100),
                 wpd_pkg::WIDTH_16, 32'd9);
    put_le(32'h7FFF8000, 4);
    put_le(32'hFFFF0000, 4);
    put_le(32'hAA, 1);
    send_file(1'b1);

    // stereo 24-bit extremes
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_STEREO, 32'd48000,
                 byte_rate_of(wpd_pkg::CHAN_STEREO, wpd_pkg::WIDTH_24, 32'd48000),
                 wpd_pkg::WIDTH_24, 32'd6);
    put_le(32'hFF800000, 4);
    put_le(32'h7FFF, 2);
    send_file(1'b1);

    // sender holds off until every result is back
    drain_results();

    // empty data chunk, then a chunk shorter than one sample
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd16000, 32'd32000, wpd_pkg::WIDTH_16,
                 32'd0);
    put_random(2);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd16000, 32'd32000, wpd_pkg::WIDTH_16,
                 32'd1);
    put_random(1);
    send_file(1'b1);

    // bad tags at the first, a middle and the last tag byte
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8,
                 32'd0);
    file_bytes[0] = 8'h72;
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8,
                 32'd0);
    file_bytes[9] = 8'h00;
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8,
                 32'd0);
    file_bytes[15] = 8'hFF;
    send_file(1'b1);

    // not pcm, bad channel counts, byte rate off by one
    build_header(16'h0003, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8, 32'd0);
    send_file(1'b1);
    build_header(16'd0, wpd_pkg::CHAN_STEREO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8, 32'd0);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, 16'd0, 32'd8000, 32'd0, wpd_pkg::WIDTH_8, 32'd0);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, 16'hFFFF, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8, 32'd0);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8001, wpd_pkg::WIDTH_8,
                 32'd0);
    send_file(1'b1);

    // largest product must not wrap
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_STEREO, 32'hFFFFFFFF,
                 byte_rate_of(wpd_pkg::CHAN_STEREO, wpd_pkg::WIDTH_24, 32'hFFFFFFFF),
                 wpd_pkg::WIDTH_24, 32'd3);
    send_file(1'b1);

    // rate check rounds down, then unsupported widths
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd3, 32'd4, 16'd12, 32'd0);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_STEREO, 32'd1000, 32'd8000, 16'd32, 32'd0);
    send_file(1'b1);

    // restart in mid-header, then in mid-data
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'd8000, 32'd8000, wpd_pkg::WIDTH_8,
                 32'd4);
    trim_to(20);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_STEREO, 32'd22050,
                 byte_rate_of(wpd_pkg::CHAN_STEREO, wpd_pkg::WIDTH_8, 32'd22050),
                 wpd_pkg::WIDTH_8, 32'd50);
    put_random(10);
    send_file(1'b1);
    build_header(wpd_pkg::FMT_PCM, wpd_pkg::CHAN_MONO, 32'hFFFF, 32'h1FFFE, wpd_pkg::WIDTH_16,
                 32'd4);
    put_le(32'h00018000, 4);
    send_file(1'b1);

    directed_bytes = bytes_sent;
    file_no = 0;

    // random files: mostly well formed, some broken, some noise
    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      idle_on = (bytes_sent - directed_bytes < CALM_AFTER) && ($urandom_range(0, 3) != 0);
      if (file_no % 6 == 0) drain_results();
      pick = $urandom_range(0, 9);
      sof = 1'b1;
      fmt = wpd_pkg::FMT_PCM;
      ch = 16'($urandom_range(1, 2));
      bw = 16'(8 * $urandom_range(1, 3));
      sr = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 32'h0AAAAAAA);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(37, 120) : $urandom_range(0, 24);
      br = byte_rate_of(ch, bw, sr);
      flaw = $urandom_range(0, 4);
      if (pick >= 7 && pick < 9) begin
        case (flaw)
          1: begin
            fmt = 16'($urandom_range(0, 65535));
            if (fmt == wpd_pkg::FMT_PCM) fmt = 16'd0;
          end
          2: ch = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(3, 65535));
          3: br = br ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)));
          4: begin
            bw = 16'($urandom_range(0, 65535));
            if (bw == wpd_pkg::WIDTH_8 || bw == wpd_pkg::WIDTH_16 || bw == wpd_pkg::WIDTH_24)
              bw = bw + 16'd1;
            br = byte_rate_of(ch, bw, sr);
          end
          default: ;
        endcase
      end
      if (pick < 9) begin
        if (pick < 7 && $urandom_range(0, 9) == 0) len = $urandom;
        build_header(fmt, ch, sr, br, bw, len);
        if (pick >= 7 && flaw == 0) begin
          cut = $urandom_range(0, 11);
          cut = (cut < 4) ? cut : cut + 4;
          file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
        end
        if (pick < 7) begin
          put_random((len > 32'd120) ? 30 : int'(len));
          put_random($urandom_range(0, 3));
          // sometimes cut short so the next file restarts mid-stream
          if ($urandom_range(0, 7) == 0) trim_to($urandom_range(1, file_bytes.size()));
        end else begin
          put_random($urandom_range(0, 4));
        end
      end else begin
        file_bytes.delete();
        put_random($urandom_range(1, 60));
        sof = ($urandom_range(0, 1) == 0);
      end
      send_file(sof);
      file_no++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    idle_on = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes in %0d files: %0d headers accepted, %0d rejected",
             bytes_sent, files_sent, n_accepts, n_rejects);
    $display("%0d decoded samples compared, %0d failures", n_samples, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("wav_pcm_stream_decoder_tb: done, clean");
    end else begin
      $display("wav_pcm_stream_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
